@@ sv/rfla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfla_pkg
// Operation codes, status codes and controller states shared by the
// reference-counted free-list allocator.
// ----------------------------------------------------------------------------
package rfla_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 3;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLONE  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCK   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNLOCK = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
    localparam logic [ST_W-1:0] STAT_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] STAT_LOCKED    = 3'd2;
    localparam logic [ST_W-1:0] STAT_REFUSED   = 3'd3;
    localparam logic [ST_W-1:0] STAT_SATURATED = 3'd4;
    localparam logic [ST_W-1:0] STAT_PLAIN     = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

endpackage

@@ sv/refcounted_free_list_allocator.sv @@
`timescale 1ns / 1ps
// Result: on accept the transaction is captured and the link and count memories are read;
//   the read-modify-write then registers the result, waiting while an earlier one is held.
// A new transaction is accepted only in S_IDLE, after the previous read-modify-write.
// A waiting result does not block the next input transaction's memory read.
// Reset: control, list head, watermark and used count clear at once; refcount_enable
//   resets to 1; link and count memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_free_list_allocator
// Fixed pool of buffer indices with a LIFO free list, a fresh-index watermark
// and a per-entry reference count held in synchronous memories.
// ----------------------------------------------------------------------------
module refcounted_free_list_allocator
    import rfla_pkg::*;
#(
    parameter int POOL_ENTRIES = 256,
    parameter int REF_BITS     = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      opcode,
    input  logic [7:0]      entry_index,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      result_index,
    output logic [2:0]      status,
    output logic [8:0]      used_count,
    output logic [15:0]     ref_count
);

    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_ENTRIES);

    logic [IDX_W-1:0]    next_free_mem [POOL_ENTRIES];
    logic [REF_BITS-1:0] refs_mem      [POOL_ENTRIES];

    ctrl_state_t         state_reg, state_next;
    logic                refcount_enable_reg;
    logic [IDX_W-1:0]    list_head_reg, list_head_next;
    logic                nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic [CNT_W-1:0]    in_use_reg, in_use_next;
    logic                out_valid_reg, out_valid_next;

    logic [OP_W-1:0]     op_reg;
    logic [7:0]          idx_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                valid_reg;
    logic [IDX_W-1:0]    nf_rd_reg;
    logic [REF_BITS-1:0] refs_rd_reg;

    logic [7:0]          result_index_reg, res_idx_next;
    logic [ST_W-1:0]     status_reg, status_next;
    logic [8:0]          used_count_reg;
    logic [15:0]         ref_count_reg;
    logic [REF_BITS-1:0] count_next;

    logic                accept;
    logic                load_out;
    logic [IDX_W+7:0]    in_idx_ext;
    logic [IDX_W-1:0]    in_addr;
    logic [IDX_W-1:0]    alloc_idx;
    logic [IDX_W+7:0]    alloc_ext;
    logic [31:0]         used_ext;
    logic [31:0]         count_ext;

    logic                refs_we;
    logic [IDX_W-1:0]    refs_waddr;
    logic [REF_BITS-1:0] refs_wdata;
    logic                nf_we;
    logic [IDX_W-1:0]    nf_wdata;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_idx_ext = {{IDX_W{1'b0}}, entry_index};
    assign in_addr    = in_idx_ext[IDX_W-1:0];
    assign alloc_ext  = {8'd0, alloc_idx};
    assign used_ext   = 32'(in_use_next);
    assign count_ext  = 32'(count_next);

    always_comb
    begin
        state_next     = state_reg;
        list_head_next = list_head_reg;
        nonempty_next  = nonempty_reg;
        fresh_next     = fresh_reg;
        in_use_next    = in_use_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        alloc_idx      = fresh_reg[IDX_W-1:0];
        res_idx_next   = idx_reg;
        status_next    = STAT_OK;
        count_next     = '0;
        refs_we        = 1'b0;
        refs_waddr     = addr_reg;
        refs_wdata     = '0;
        nf_we          = 1'b0;
        nf_wdata       = nonempty_reg ? list_head_reg : addr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if (fresh_reg < POOL_CNT || nonempty_reg)
                            begin
                                if (fresh_reg < POOL_CNT)
                                begin
                                    alloc_idx  = fresh_reg[IDX_W-1:0];
                                    fresh_next = fresh_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    alloc_idx = list_head_reg;
                                    if (nf_rd_reg == list_head_reg)
                                    begin
                                        nonempty_next = 1'b0;
                                    end
                                    else
                                    begin
                                        list_head_next = nf_rd_reg;
                                    end
                                end
                                refs_we    = 1'b1;
                                refs_waddr = alloc_idx;
                                refs_wdata = REF_BITS'(1);
                                if (in_use_reg < POOL_CNT)
                                begin
                                    in_use_next = in_use_reg + CNT_W'(1);
                                end
                                res_idx_next = alloc_ext[7:0];
                                count_next   = REF_BITS'(1);
                            end
                            else
                            begin
                                res_idx_next = 8'd0;
                                status_next  = STAT_EMPTY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            list_head_next = '0;
                            nonempty_next  = 1'b0;
                            fresh_next     = '0;
                            in_use_next    = '0;
                        end
                        OP_FREE, OP_CLONE, OP_LOCK, OP_UNLOCK:
                        begin
                            if (valid_reg)
                            begin
                                count_next = refs_rd_reg;
                                if (op_reg == OP_FREE)
                                begin
                                    if (!refcount_enable_reg || refs_rd_reg <= REF_BITS'(1))
                                    begin
                                        nf_we          = 1'b1;
                                        list_head_next = addr_reg;
                                        nonempty_next  = 1'b1;
                                        count_next     = '0;
                                        if (in_use_reg != '0)
                                        begin
                                            in_use_next = in_use_reg - CNT_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        count_next = refs_rd_reg - REF_BITS'(1);
                                    end
                                end
                                else if (!refcount_enable_reg)
                                begin
                                    status_next = STAT_PLAIN;
                                end
                                else if (op_reg == OP_CLONE)
                                begin
                                    if (refs_rd_reg == '0)
                                    begin
                                        status_next = STAT_LOCKED;
                                    end
                                    else if (refs_rd_reg == '1)
                                    begin
                                        status_next = STAT_SATURATED;
                                    end
                                    else
                                    begin
                                        count_next = refs_rd_reg + REF_BITS'(1);
                                    end
                                end
                                else if (op_reg == OP_LOCK)
                                begin
                                    if (refs_rd_reg > REF_BITS'(1))
                                    begin
                                        status_next = STAT_REFUSED;
                                    end
                                    else
                                    begin
                                        count_next = '0;
                                    end
                                end
                                else
                                begin
                                    if (refs_rd_reg == '0)
                                    begin
                                        count_next = REF_BITS'(1);
                                    end
                                end
                                refs_we    = 1'b1;
                                refs_wdata = count_next;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            refcount_enable_reg <= 1'b1;
            list_head_reg       <= '0;
            nonempty_reg        <= 1'b0;
            fresh_reg           <= '0;
            in_use_reg          <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            nonempty_reg  <= nonempty_next;
            fresh_reg     <= fresh_next;
            in_use_reg    <= in_use_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                refcount_enable_reg <= cfg_wr_data;
            end
        end
    end

    // capture the transaction and issue memory reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            idx_reg     <= entry_index;
            addr_reg    <= in_addr;
            valid_reg   <= (32'(entry_index) < POOL_ENTRIES);
            nf_rd_reg   <= next_free_mem[list_head_reg];
            refs_rd_reg <= refs_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nf_we)
        begin
            next_free_mem[addr_reg] <= nf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs_we)
        begin
            refs_mem[refs_waddr] <= refs_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_index_reg <= res_idx_next;
            status_reg       <= status_next;
            used_count_reg   <= used_ext[8:0];
            ref_count_reg    <= count_ext[15:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = result_index_reg;
    assign status       = status_reg;
    assign used_count   = used_count_reg;
    assign ref_count    = ref_count_reg;

endmodule
